[hw/rtl/fcl_pkg.sv]
// Shared types, constants and sigmoid table for the dense layer block.
// No dependencies; every other file in hw/rtl except fcl_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none
package fcl_pkg;

   localparam int MAX_INPUTS  = 256;
   localparam int MAX_NEURONS = 64;
   localparam int DATA_WIDTH  = 16;
   localparam int IDX_W       = $clog2(MAX_INPUTS);
   localparam int NRN_W       = $clog2(MAX_NEURONS);
   localparam int WADDR_W     = IDX_W + NRN_W;
   localparam int WDEPTH      = MAX_INPUTS * MAX_NEURONS;
   localparam int ACC_W       = 42;
   localparam int HALF_W      = ACC_W / 2;
   localparam int P_W         = 40;
   localparam int KF_W        = 17;

   localparam logic [1:0] CMD_WEIGHT  = 2'd0;
   localparam logic [1:0] CMD_BIAS    = 2'd1;
   localparam logic [1:0] CMD_ELEMENT = 2'd2;

   localparam logic [2:0] REG_INPUT_COUNT  = 3'd0;
   localparam logic [2:0] REG_NEURON_COUNT = 3'd1;
   localparam logic [2:0] REG_ACTIVATION   = 3'd2;
   localparam logic [2:0] REG_DROPOUT      = 3'd3;
   localparam logic [2:0] REG_KEEP_FACTOR  = 3'd4;

   localparam logic [1:0] DROP_MASK  = 2'd1;
   localparam logic [1:0] DROP_SCALE = 2'd2;
   localparam logic       ACT_SIGMOID = 1'b1;

   localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MAC, ST_DRAIN1, ST_DRAIN2, ST_BIAS,
      ST_SCALE_LO, ST_SCALE_HI, ST_ROUND, ST_OUT
   } state_type;

   typedef struct packed {
      logic               accept;
      logic               clear_wr;
      logic [WADDR_W-1:0] clear_addr;
      logic               rd_issue;
      logic [NRN_W-1:0]   rd_neuron;
      logic [IDX_W-1:0]   rd_input;
      logic               acc_clear;
      logic               bias_add;
      logic               scale_lo;
      logic               scale_hi;
      logic               round_en;
      logic               out_en;
      logic               out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0] inputs_m1;
      logic [NRN_W-1:0] neurons_m1;
   } dp_stat_type;

   typedef logic [15:0] sig_tab_type [256];

   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], n[i]};
         if (r >= d) begin
            r = r - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic sig_tab_type build_sig();
      sig_tab_type t;
      logic [63:0] e;
      logic [63:0] den;
      e = EXP_STEP_Q32;
      for (int k = 0; k < 128; k++) begin
         den = 64'h1_0000_0000 + e;
         t[128 + k] = 16'(udiv((64'd1 << 40) + (den >> 1), den));
         t[127 - k] = 16'(udiv((e << 8) + (den >> 1), den));
         e = (e * EXP_STEP_Q32) >> 32;
         e = (e * EXP_STEP_Q32) >> 32;
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TABLE = build_sig();

endpackage
`default_nettype wire

[hw/rtl/fully_connected_layer_forward.sv]
// A closing element starts the pass. Per neuron: MAC over the N inputs in use, drain,
// bias, scale low/high, round, output; busy stays high over all M neurons.
// Throughput: one MAC over the weight RAM, one product per cycle while in the MAC state.
// Reset: a sweep over all 16384 weight words sets all keep bits; busy stays high until it ends.
// Write requests are taken only while idle. Results strobe once; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module fully_connected_layer_forward (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_command,
   input  wire logic [fcl_pkg::NRN_W-1:0]  req_neuron_index,
   input  wire logic [fcl_pkg::IDX_W-1:0]  req_input_index,
   input  wire logic signed [15:0]         req_value,
   input  wire logic                       req_keep_bit,
   output logic                            rsp_valid,
   output logic [fcl_pkg::NRN_W-1:0]       rsp_out_neuron,
   output logic signed [15:0]              rsp_activation_value,
   output logic                            rsp_last_output,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [fcl_pkg::KF_W-1:0]   csr_data
);
   fcl_pkg::dp_cmd_type  cmd;
   fcl_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   fcl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .req_command(req_command), .req_input_index(req_input_index),
      .stat(stat), .busy(busy), .cmd(cmd));

   fcl_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_command(req_command), .req_neuron_index(req_neuron_index),
      .req_input_index(req_input_index), .req_value(req_value),
      .req_keep_bit(req_keep_bit),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_out_neuron(rsp_out_neuron),
      .rsp_activation_value(rsp_activation_value), .rsp_last_output(rsp_last_output));

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result strobes");
   a_clear_busy: assert property (@(posedge clock)
      reset |=> busy) else $error("not busy after reset");
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_output |-> busy) else $error("idle mid-vector");
`endif
endmodule
`default_nettype wire

[hw/rtl/fcl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[hw/rtl/fcl_ctrl.sv]
// Controller: clearing sweep, request decode and per-neuron MAC sequencing.
// Depends on fcl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fcl_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [1:0]               req_command,
   input  wire logic [fcl_pkg::IDX_W-1:0] req_input_index,
   input  wire fcl_pkg::dp_stat_type     stat,
   output logic                          busy,
   output fcl_pkg::dp_cmd_type           cmd
);
   fcl_pkg::state_type state_ff, state_in;
   logic [fcl_pkg::WADDR_W-1:0] clr_ff, clr_in;
   logic [fcl_pkg::IDX_W-1:0]   j_ff, j_in;
   logic [fcl_pkg::NRN_W-1:0]   k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcl_pkg::ST_CLEAR;
         clr_ff   <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd            = '0;
      cmd.clear_addr = clr_ff;
      cmd.rd_neuron  = k_ff;
      cmd.rd_input   = j_ff;
      cmd.out_last   = (k_ff == stat.neurons_m1);
      busy = (state_ff != fcl_pkg::ST_IDLE);
      case (state_ff)
         fcl_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = fcl_pkg::ST_IDLE;
            end
         end
         fcl_pkg::ST_IDLE: begin
            cmd.accept = start;
            if (start && req_command == fcl_pkg::CMD_ELEMENT
                  && req_input_index == stat.inputs_m1) begin
               cmd.acc_clear = 1'b1;
               j_in = '0;
               k_in = '0;
               state_in = fcl_pkg::ST_MAC;
            end
         end
         fcl_pkg::ST_MAC: begin
            cmd.rd_issue = 1'b1;
            j_in = j_ff + 1'b1;
            if (j_ff == stat.inputs_m1) begin
               state_in = fcl_pkg::ST_DRAIN1;
            end
         end
         fcl_pkg::ST_DRAIN1:   state_in = fcl_pkg::ST_DRAIN2;
         fcl_pkg::ST_DRAIN2:   state_in = fcl_pkg::ST_BIAS;
         fcl_pkg::ST_BIAS: begin
            cmd.bias_add = 1'b1;
            state_in = fcl_pkg::ST_SCALE_LO;
         end
         fcl_pkg::ST_SCALE_LO: begin
            cmd.scale_lo = 1'b1;
            state_in = fcl_pkg::ST_SCALE_HI;
         end
         fcl_pkg::ST_SCALE_HI: begin
            cmd.scale_hi = 1'b1;
            state_in = fcl_pkg::ST_ROUND;
         end
         fcl_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in = fcl_pkg::ST_OUT;
         end
         fcl_pkg::ST_OUT: begin
            cmd.out_en = 1'b1;
            j_in = '0;
            if (k_ff == stat.neurons_m1) begin
               state_in = fcl_pkg::ST_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
               cmd.acc_clear = 1'b1;
               state_in = fcl_pkg::ST_MAC;
            end
         end
         default: state_in = fcl_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[hw/rtl/fcl_dp.sv]
// Datapath: config registers, weight/bias/vector RAMs, MAC, scaling, activation.
// Depends on fcl_pkg and fcl_ram.
`timescale 1ns / 1ps
`default_nettype none
module fcl_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fcl_pkg::dp_cmd_type        cmd,
   output fcl_pkg::dp_stat_type            stat,
   input  wire logic [1:0]                 req_command,
   input  wire logic [fcl_pkg::NRN_W-1:0]  req_neuron_index,
   input  wire logic [fcl_pkg::IDX_W-1:0]  req_input_index,
   input  wire logic signed [15:0]         req_value,
   input  wire logic                       req_keep_bit,
   input  wire logic                       csr_we,
   input  wire logic [2:0]                 csr_index,
   input  wire logic [fcl_pkg::KF_W-1:0]   csr_data,
   output logic                            rsp_valid,
   output logic [fcl_pkg::NRN_W-1:0]       rsp_out_neuron,
   output logic signed [15:0]              rsp_activation_value,
   output logic                            rsp_last_output
);
   localparam int AW = fcl_pkg::ACC_W;
   localparam int HW = fcl_pkg::HALF_W;
   localparam int PW = fcl_pkg::P_W;

   logic [8:0]  icount_ff;
   logic [6:0]  ncount_ff;
   logic        act_ff;
   logic [1:0]  drop_ff;
   logic [16:0] kf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         icount_ff <= 9'd256;
         ncount_ff <= 7'd64;
         act_ff    <= 1'b0;
         drop_ff   <= 2'd0;
         kf_ff     <= 17'd65536;
      end else if (csr_we) begin
         case (csr_index)
            fcl_pkg::REG_INPUT_COUNT:  icount_ff <= csr_data[8:0];
            fcl_pkg::REG_NEURON_COUNT: ncount_ff <= csr_data[6:0];
            fcl_pkg::REG_ACTIVATION:   act_ff    <= csr_data[0];
            fcl_pkg::REG_DROPOUT:      drop_ff   <= csr_data[1:0];
            fcl_pkg::REG_KEEP_FACTOR:  kf_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (icount_ff == 9'd0) begin
         stat.inputs_m1 = '0;
      end else if (icount_ff > 9'(fcl_pkg::MAX_INPUTS)) begin
         stat.inputs_m1 = fcl_pkg::IDX_W'(fcl_pkg::MAX_INPUTS - 1);
      end else begin
         stat.inputs_m1 = fcl_pkg::IDX_W'(icount_ff - 9'd1);
      end
      if (ncount_ff == 7'd0) begin
         stat.neurons_m1 = '0;
      end else if (ncount_ff > 7'(fcl_pkg::MAX_NEURONS)) begin
         stat.neurons_m1 = fcl_pkg::NRN_W'(fcl_pkg::MAX_NEURONS - 1);
      end else begin
         stat.neurons_m1 = fcl_pkg::NRN_W'(ncount_ff - 7'd1);
      end
   end

   logic [16:0] kf_eff;
   assign kf_eff = (kf_ff > 17'd65536) ? 17'd65536 : kf_ff;

   // memories
   logic        w_we, b_we, v_we;
   logic [fcl_pkg::WADDR_W-1:0] w_waddr;
   logic [16:0] w_wdata, w_rdata;
   logic [15:0] b_rdata, v_rdata;

   assign w_we    = cmd.clear_wr || (cmd.accept && req_command == fcl_pkg::CMD_WEIGHT);
   assign w_waddr = cmd.clear_wr ? cmd.clear_addr : {req_neuron_index, req_input_index};
   assign w_wdata = cmd.clear_wr ? {1'b1, 16'h0000} : {req_keep_bit, req_value};
   assign b_we    = cmd.accept && req_command == fcl_pkg::CMD_BIAS;
   assign v_we    = cmd.accept && req_command == fcl_pkg::CMD_ELEMENT;

   fcl_ram #(.WIDTH(17), .DEPTH(fcl_pkg::WDEPTH)) u_wram (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .re(cmd.rd_issue), .raddr({cmd.rd_neuron, cmd.rd_input}), .rdata(w_rdata));

   fcl_ram #(.WIDTH(16), .DEPTH(fcl_pkg::MAX_NEURONS)) u_bram (
      .clock(clock), .we(b_we), .waddr(req_neuron_index), .wdata(req_value),
      .re(cmd.rd_issue), .raddr(cmd.rd_neuron), .rdata(b_rdata));

   fcl_ram #(.WIDTH(16), .DEPTH(fcl_pkg::MAX_INPUTS)) u_vram (
      .clock(clock), .we(v_we), .waddr(req_input_index), .wdata(req_value),
      .re(cmd.rd_issue), .raddr(cmd.rd_input), .rdata(v_rdata));

   // MAC pipeline
   logic v1_ff, v2_ff;
   logic signed [31:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic [HW+16:0] slo_ff;
   logic signed [HW+17:0] shi_ff;
   logic signed [PW-1:0] p_ff;
   logic gate;

   assign gate = (drop_ff == fcl_pkg::DROP_MASK) && !w_rdata[16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd_issue;
         v2_ff <= v1_ff;
      end
   end

   logic signed [AW+17:0] ssum;
   logic signed [AW+17:0] sround;
   logic signed [AW-1:0]  pround;

   assign ssum   = ((AW+18)'(shi_ff) <<< HW) + (AW+18)'($signed({1'b0, slo_ff}));
   assign sround = (ssum + $signed((AW+18)'(64'd1 << 23))) >>> 24;
   assign pround = (acc_ff + AW'(128)) >>> 8;

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         prod_ff <= gate ? 32'sd0 : $signed(v_rdata) * $signed(w_rdata[15:0]);
      end
      if (cmd.acc_clear) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end else if (cmd.bias_add) begin
         acc_ff <= acc_ff + (AW'($signed(b_rdata)) <<< 8);
      end
      if (cmd.scale_lo) begin
         slo_ff <= {1'b0, acc_ff[HW-1:0]} * {{(HW-16){1'b0}}, kf_eff};
      end
      if (cmd.scale_hi) begin
         shi_ff <= (HW+18)'($signed(acc_ff[AW-1:HW])) * (HW+18)'($signed({1'b0, kf_eff}));
      end
      if (cmd.round_en) begin
         p_ff <= (drop_ff == fcl_pkg::DROP_SCALE) ? PW'(sround) : PW'(pround);
      end
   end

   // activation
   logic [15:0] act_val;
   logic [11:0] sig_off;
   assign sig_off = 12'(p_ff + PW'(2048));

   always_comb begin
      if (act_ff == fcl_pkg::ACT_SIGMOID) begin
         if (p_ff < -PW'(2048)) begin
            act_val = 16'd0;
         end else if (p_ff >= PW'(2048)) begin
            act_val = 16'd256;
         end else begin
            act_val = fcl_pkg::SIG_TABLE[sig_off[11:4]];
         end
      end else if (p_ff < 0) begin
         act_val = 16'd0;
      end else if (p_ff > PW'((64'd1 << (fcl_pkg::DATA_WIDTH - 1)) - 1)) begin
         act_val = 16'((64'd1 << (fcl_pkg::DATA_WIDTH - 1)) - 1);
      end else begin
         act_val = p_ff[15:0];
      end
   end

   logic                      rv_ff;
   logic [fcl_pkg::NRN_W-1:0] rn_ff;
   logic [15:0]               ra_ff;
   logic                      rl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= cmd.out_en;
      end
      if (cmd.out_en) begin
         rn_ff <= cmd.rd_neuron;
         ra_ff <= act_val;
         rl_ff <= cmd.out_last;
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_out_neuron       = rn_ff;
   assign rsp_activation_value = ra_ff;
   assign rsp_last_output      = rl_ff;
endmodule
`default_nettype wire
